// File: sv/gdn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gdn_pkg;
    localparam int FIRST_YEAR_C = 1601;
    localparam int LAST_YEAR_C  = 9999;
    localparam int SERIAL_W     = 22;
    // holds the offset sum and the top serial number up to LAST_YEAR 65535
    localparam int SUM_W        = 25;

    // Front-end classification handed to the back end.
    typedef enum logic [1:0] {
        OP_ERROR = 2'd0,
        OP_DATE  = 2'd1,
        OP_SERIAL = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SUM_W-1:0] serial;   // func 1: checked sum
        logic [4:0]       day;
        logic [3:0]       month;
        logic [15:0]      yidx;     // year - FIRST_YEAR
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_YBASE = 3'd1,
        ST_YFIX  = 3'd2,
        ST_MON   = 3'd3,
        ST_WDAY  = 3'd4,
        ST_DONE  = 3'd5
    } be_state_t;

    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] v;
        unique case (m)
            4'd0:  v = 9'd0;
            4'd1:  v = 9'd31;
            4'd2:  v = 9'd59;
            4'd3:  v = 9'd90;
            4'd4:  v = 9'd120;
            4'd5:  v = 9'd151;
            4'd6:  v = 9'd181;
            4'd7:  v = 9'd212;
            4'd8:  v = 9'd243;
            4'd9:  v = 9'd273;
            4'd10: v = 9'd304;
            4'd11: v = 9'd334;
            default: v = 9'd365;
        endcase
        if (leap && m >= 4'd2)
            v = v + 9'd1;
        return v;
    endfunction

    // v / 100 as (v / 4) * 5243 >> 17, exact over the whole 16-bit range
    function automatic logic [15:0] div100(input logic [15:0] v);
        logic [29:0] p;
        p = 30'(v[15:2]) * 30'd5243;
        return 16'(p >> 17);
    endfunction

    // century years are leap only when the century count is a multiple of 4
    function automatic logic is_leap(input logic [15:0] y);
        logic [15:0] q;
        q = div100(y);
        return (y[1:0] == 2'b00) &&
               ((24'(q) * 24'd100 != 24'(y)) || (q[1:0] == 2'b00));
    endfunction
endpackage
`default_nettype wire

// File: sv/gdn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gdn_front
    import gdn_pkg::*;
#(
    parameter int LAST_YEAR = LAST_YEAR_C
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                func,
    input  wire logic [4:0]          in_day,
    input  wire logic [3:0]          in_month,
    input  wire logic [13:0]         in_year,
    input  wire logic [21:0]         in_serial,
    input  wire logic signed [22:0]  day_offset,
    input  wire logic [SUM_W-1:0]    max_serial,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output job_t                     q_job
);
    // two-entry queue
    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    job_t       job;
    logic       leap;
    logic [5:0] mlen;
    logic signed [SUM_W:0] sum;
    logic       push, pop;

    always_comb
    begin
        job = '0;
        leap = is_leap(16'(in_year));
        mlen = 6'(cum_days(in_month, leap) - cum_days(in_month - 4'd1, leap));
        sum = $signed({{(SUM_W-21){1'b0}}, in_serial}) +
              $signed({{(SUM_W-22){day_offset[22]}}, day_offset});
        job.day   = in_day;
        job.month = in_month;
        job.yidx  = 16'(32'(in_year) - FIRST_YEAR_C);
        if (func == 1'b0)
        begin
            if (32'(in_year) < FIRST_YEAR_C || 32'(in_year) > LAST_YEAR ||
                in_month == 4'd0 || in_month > 4'd12 ||
                in_day == 5'd0 || 6'(in_day) > mlen)
                job.op = OP_ERROR;
            else
                job.op = OP_DATE;
        end
        else
        begin
            job.serial = SUM_W'(sum);
            if (sum < 1 || sum > $signed({1'b0, max_serial}))
                job.op = OP_ERROR;
            else
                job.op = OP_SERIAL;
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_job    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_cnt_le2: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !pop) else $error("pop while empty");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count slip");
endmodule
`default_nettype wire

// File: sv/gdn_back.sv
`timescale 1ns / 1ps
`default_nettype none
module gdn_back
    import gdn_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire job_t                q_job,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [21:0]              out_serial,
    output logic [4:0]               out_day,
    output logic [3:0]               out_month,
    output logic [13:0]              out_year,
    output logic [2:0]               weekday,
    output logic                     error
);
    be_state_t        st_reg, st_next;
    job_t             job_reg;
    logic [15:0]      n_reg;
    logic [SUM_W-1:0] base_reg, r_reg, wrem_reg;
    logic [3:0]       m_reg;
    logic [21:0]      o_serial_reg;
    logic [4:0]       o_day_reg;
    logic [3:0]       o_month_reg;
    logic [13:0]      o_year_reg;
    logic [2:0]       o_wday_reg;
    logic             o_err_reg;

    logic [SUM_W-1:0] dbase;
    logic [15:0]      yr;
    logic             leap;
    logic [SUM_W-1:0] doy;

    // days in n whole years: n*365 + n/4 - n/100 + n/400
    function automatic logic [SUM_W-1:0] days_in(input logic [15:0] n);
        logic [15:0] c;
        c = div100(n);
        return SUM_W'(32'(n) * 32'd365 + 32'(n >> 2) - 32'(c) + 32'(c >> 2));
    endfunction

    // year count estimate, never below v / 365 and at most one above
    function automatic logic [15:0] est365(input logic [SUM_W-1:0] v);
        logic [47:0] p;
        p = 48'(v) * 48'd45966;
        return 16'(p >> 24);
    endfunction

    // 8 = 1 mod 7: summing the octal digits keeps the residue
    function automatic logic [SUM_W-1:0] oct_sum(input logic [SUM_W-1:0] v);
        logic [26:0]      w;
        logic [SUM_W-1:0] s;
        w = 27'(v);
        s = '0;
        for (int i = 0; i < 9; i++)
            s = s + SUM_W'(w[3*i +: 3]);
        return s;
    endfunction

    always_comb
    begin
        dbase = days_in(n_reg);
        yr    = n_reg + 16'(FIRST_YEAR_C);
        leap  = is_leap(yr);
        doy   = r_reg - base_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    always_comb
    begin
        st_next = st_reg;
        q_ready = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                    st_next = (q_job.op == OP_ERROR) ? ST_DONE : ST_YBASE;
            end
            ST_YBASE: st_next = (job_reg.op == OP_DATE) ? ST_WDAY : ST_YFIX;
            ST_YFIX:
                if (!(base_reg >= r_reg && n_reg != 0))
                    st_next = ST_MON;
            ST_MON:
                if (!(m_reg < 4'd12 && doy > SUM_W'(cum_days(m_reg, leap))))
                    st_next = ST_WDAY;
            ST_WDAY:
                if (wrem_reg < SUM_W'(7))
                    st_next = ST_DONE;
            ST_DONE:
                if (out_ready)
                    st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    job_reg   <= q_job;
                    r_reg     <= q_job.serial;
                    n_reg     <= (q_job.op == OP_DATE) ? q_job.yidx
                                 : est365(q_job.serial);
                    m_reg     <= 4'd1;
                    o_err_reg <= (q_job.op == OP_ERROR);
                end
            ST_YBASE:
            begin
                base_reg <= dbase;
                if (job_reg.op == OP_DATE)
                begin
                    r_reg       <= dbase + SUM_W'(cum_days(job_reg.month - 4'd1, leap))
                                   + SUM_W'(job_reg.day);
                    wrem_reg    <= dbase + SUM_W'(cum_days(job_reg.month - 4'd1, leap))
                                   + SUM_W'(job_reg.day) - SUM_W'(1);
                    o_day_reg   <= job_reg.day;
                    o_month_reg <= job_reg.month;
                    o_year_reg  <= 14'(yr);
                end
            end
            ST_YFIX:
                if (base_reg >= r_reg && n_reg != 0)
                begin
                    n_reg    <= n_reg - 16'd1;
                    base_reg <= days_in(n_reg - 16'd1);
                end
            ST_MON:
                if (m_reg < 4'd12 && doy > SUM_W'(cum_days(m_reg, leap)))
                    m_reg <= m_reg + 4'd1;
                else
                begin
                    o_day_reg   <= 5'(doy - SUM_W'(cum_days(m_reg - 4'd1, leap)));
                    o_month_reg <= m_reg;
                    o_year_reg  <= 14'(yr);
                    wrem_reg    <= r_reg - SUM_W'(1);
                end
            ST_WDAY:
                // fold octal digits until the residue is below 7
                if (wrem_reg >= SUM_W'(8))
                    wrem_reg <= oct_sum(wrem_reg);
                else if (wrem_reg == SUM_W'(7))
                    wrem_reg <= '0;
            default: ;
        endcase
        if (st_reg == ST_WDAY)
        begin
            o_serial_reg <= 22'(r_reg);
            o_wday_reg   <= 3'(wrem_reg);
        end
    end

    assign out_valid  = (st_reg == ST_DONE);
    assign out_serial = o_err_reg ? '0 : o_serial_reg;
    assign out_day    = o_err_reg ? '0 : o_day_reg;
    assign out_month  = o_err_reg ? '0 : o_month_reg;
    assign out_year   = o_err_reg ? '0 : o_year_reg;
    assign weekday    = o_err_reg ? '0 : o_wday_reg;
    assign error      = o_err_reg;

    a_mon: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_MON |-> m_reg >= 4'd1 && m_reg <= 4'd12) else $error("month range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> st_reg == ST_IDLE) else $error("took job while busy");
endmodule
`default_nettype wire

// File: sv/gregorian_day_number_convert.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | signals                                        | dir
// in      | in_valid/in_ready, func, in_day..day_offset    | sink
// out     | out_valid/out_ready, out_serial..error         | source
// Front end checks the date or the offset sum combinationally and queues the job
// (two entries). The back end runs one job at a time: for a date (base,
// weekday folds, result) and for a serial number (reciprocal year estimate,
// year step-downs, month steps, weekday folds). Errors go straight to the
// result. Reset clears the queue and sequencer. The queue lets input
// transfers continue while a result waits.
module gregorian_day_number_convert
    import gdn_pkg::*;
#(
    parameter int LAST_YEAR = LAST_YEAR_C
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               func,
    input  wire logic [4:0]         in_day,
    input  wire logic [3:0]         in_month,
    input  wire logic [13:0]        in_year,
    input  wire logic [21:0]        in_serial,
    input  wire logic signed [22:0] day_offset,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [21:0]             out_serial,
    output logic [4:0]              out_day,
    output logic [3:0]              out_month,
    output logic [13:0]             out_year,
    output logic [2:0]              weekday,
    output logic                    error
);
    localparam int NY = LAST_YEAR - FIRST_YEAR_C + 1;
    localparam logic [SUM_W-1:0] MAX_SERIAL =
        SUM_W'(NY * 365 + NY / 4 - NY / 100 + NY / 400);

    logic q_valid, q_ready;
    job_t q_job;

    gdn_front #(.LAST_YEAR(LAST_YEAR)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .func, .in_day, .in_month, .in_year,
        .in_serial, .day_offset, .max_serial(MAX_SERIAL),
        .q_valid, .q_ready, .q_job
    );

    gdn_back u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_job, .out_valid, .out_ready,
        .out_serial, .out_day, .out_month, .out_year, .weekday, .error
    );
endmodule
`default_nettype wire
